// File: rtl/sss_pkg.sv
// Shared types, command codes and arithmetic helpers for the seek-steering block.
// No dependencies; imported by the root, divider, datapath, sequencer, top level and testbench.
package sss_pkg;

  localparam int unsigned CFG_W   = 23;  // width of the length limits
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STEPS   = 32;  // root digits / quotient bits per run

  typedef enum logic [2:0] {
    CFG_MAX_SPEED     = 3'd0,
    CFG_MAX_PUSH      = 3'd1,
    CFG_ARRIVE_RADIUS = 3'd2,
    CFG_START_X       = 3'd3,
    CFG_START_Y       = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD, ST_SQX, ST_SQY, ST_MM, ST_CMP, ST_ROOT, ST_MULX, ST_MULY,
    ST_DIVGO, ST_DIV, ST_WB, ST_SPADD, ST_PLACE, ST_PUPD, ST_FIN
  } state_t;

  typedef enum logic [1:0] {PH_ARR, PH_PUSH, PH_SPEED, PH_DIR} phase_t;

  typedef enum logic [1:0] {LD_NONE, LD_PUSH, LD_SPEED, LD_DIR} ld_sel_t;
  typedef enum logic [2:0] {MUL_XX, MUL_YY, MUL_MM, MUL_XM, MUL_YM} mul_sel_t;
  typedef enum logic [1:0] {M_SPEED, M_PUSH, M_RADIUS} m_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [3:0] {
    WB_NONE, WB_PUSH_CLAMP, WB_SPEED_ADD, WB_SPEED_CLAMP, WB_PLACE, WB_W,
    WB_PUSH_UPD, WB_GOAL, WB_REACH
  } wb_t;

  typedef struct packed {
    ld_sel_t  ld_sel;
    mul_sel_t mul_sel;
    m_sel_t   m_sel;
    acc_op_t  acc_op;
    logic     cap_x;
    logic     root_go;
    logic     div_go;
    wb_t      wb;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic gt;         // sum of squares above limit squared
    logic nz;         // sum of squares nonzero
    logic root_busy;
    logic div_busy;
  } sts_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end
    return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

// File: rtl/sss_if.sv
// Valid/ready channel interfaces for the seek-steering block.
// No dependencies.
interface sss_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  modport source (output valid, operation, target_x, target_y, input ready);
  modport sink (input valid, operation, target_x, target_y, output ready);
endinterface

interface sss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic               at_goal;
  modport source (output valid, position_x, position_y, velocity_x, velocity_y, at_goal,
                  input ready);
  modport sink (input valid, position_x, position_y, velocity_x, velocity_y, at_goal,
                output ready);
endinterface

// File: rtl/sss_root.sv
// Iterative floor square root of a 64-bit value, one root bit per cycle.
// Depends on sss_pkg.
module sss_root import sss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);
  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] v_r, v_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [35:0] sh, trial;

  assign sh    = {rem_r, v_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      v_nxt = {v_r[61:0], 2'b00};
      if (sh >= trial) begin
        rem_nxt  = 34'(sh - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = sh[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;
endmodule

// File: rtl/sss_div.sv
// Restoring divider, one quotient bit per cycle; dividend high word below divisor.
// Depends on sss_pkg.
module sss_div import sss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quot
);
  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, q_r, q_nxt, d_r, d_nxt;
  logic [32:0] sh;

  assign sh = {rem_r, q_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[63:32];
      q_nxt    = dividend[31:0];
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = 32'(sh - {1'b0, d_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = sh[31:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule

// File: rtl/sss_dp.sv
// Datapath: steering state, shared multiplier, accumulator, root and dividers.
// Depends on sss_pkg, sss_root, sss_div.
module sss_dp import sss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [CFG_W-1:0]   max_speed,
  input  logic [CFG_W-1:0]   max_push,
  input  logic [CFG_W-1:0]   arrive_radius,
  input  logic signed [31:0] in_tx,
  input  logic signed [31:0] in_ty,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic               at_goal
);
  logic signed [31:0] place_x_r, place_y_r, speed_x_r, speed_y_r;
  logic signed [31:0] push_x_r, push_y_r, goal_x_r, goal_y_r;
  logic               reached_r;
  logic signed [31:0] wx_r, wy_r;
  logic [31:0]        ax_r, ay_r;
  logic               nx_r, ny_r;
  logic [63:0]        p_r, acc_r, dvx_r;
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic               at_goal_r;

  logic signed [32:0] dx, dy;
  logic [32:0]        mdx, mdy;
  logic               big;
  logic [CFG_W-1:0]   m_val;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [31:0]        len, qx, qy;
  logic               root_busy, divx_busy, divy_busy;
  logic signed [31:0] sqx, sqy;
  logic               near;

  // goal minus place, with magnitudes halved together when either is huge
  assign dx  = 33'(goal_x_r) - 33'(place_x_r);
  assign dy  = 33'(goal_y_r) - 33'(place_y_r);
  assign mdx = dx[32] ? 33'(-dx) : 33'(dx);
  assign mdy = dy[32] ? 33'(-dy) : 33'(dy);
  assign big = mdx[32] | mdx[31] | mdy[32] | mdy[31];

  always_comb begin
    case (cmd.m_sel)
      M_PUSH:   m_val = max_push;
      M_RADIUS: m_val = arrive_radius;
      default:  m_val = max_speed;
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_XX:  begin mul_a = ax_r;             mul_b = ax_r;             end
      MUL_YY:  begin mul_a = ay_r;             mul_b = ay_r;             end
      MUL_MM:  begin mul_a = 32'(m_val);       mul_b = 32'(m_val);       end
      MUL_XM:  begin mul_a = ax_r;             mul_b = 32'(m_val);       end
      MUL_YM:  begin mul_a = ay_r;             mul_b = 32'(m_val);       end
      default: begin mul_a = ax_r;             mul_b = ax_r;             end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  sss_root u_root (
    .clk, .rst_n, .go(cmd.root_go), .radicand(acc_r), .busy(root_busy), .root(len)
  );
  sss_div u_divx (
    .clk, .rst_n, .go(cmd.div_go), .dividend(dvx_r), .divisor(len),
    .busy(divx_busy), .quot(qx)
  );
  sss_div u_divy (
    .clk, .rst_n, .go(cmd.div_go), .dividend(p_r), .divisor(len),
    .busy(divy_busy), .quot(qy)
  );

  assign sqx  = nx_r ? 32'(-qx) : 32'(qx);
  assign sqy  = ny_r ? 32'(-qy) : 32'(qy);
  assign near = (ax_r < 32'(arrive_radius)) && (ay_r < 32'(arrive_radius)) && (acc_r < p_r);

  assign sts.gt        = acc_r > p_r;
  assign sts.nz        = acc_r != '0;
  assign sts.root_busy = root_busy;
  assign sts.div_busy  = divx_busy | divy_busy;

  // operand load and arithmetic work registers
  always_ff @(posedge clk) begin
    case (cmd.ld_sel)
      LD_PUSH: begin
        ax_r <= abs32(push_x_r); ay_r <= abs32(push_y_r);
        nx_r <= push_x_r[31];    ny_r <= push_y_r[31];
      end
      LD_SPEED: begin
        ax_r <= abs32(speed_x_r); ay_r <= abs32(speed_y_r);
        nx_r <= speed_x_r[31];    ny_r <= speed_y_r[31];
      end
      LD_DIR: begin
        ax_r <= big ? mdx[32:1] : mdx[31:0];
        ay_r <= big ? mdy[32:1] : mdy[31:0];
        nx_r <= dx[32];
        ny_r <= dy[32];
      end
      default: ;
    endcase
    p_r <= mul_p;
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= p_r;
      ACC_ADD:  acc_r <= acc_r + p_r;
      default:  ;
    endcase
    if (cmd.cap_x) dvx_r <= p_r;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_x_r <= '0; place_y_r <= '0;
      speed_x_r <= '0; speed_y_r <= '0;
      push_x_r  <= '0; push_y_r  <= '0;
      goal_x_r  <= '0; goal_y_r  <= '0;
      reached_r <= 1'b0;
      wx_r      <= '0; wy_r      <= '0;
    end else begin
      if (cmd.ld_sel == LD_DIR) begin
        wx_r <= '0;
        wy_r <= '0;
      end
      case (cmd.wb)
        WB_PUSH_CLAMP:  begin push_x_r <= sqx; push_y_r <= sqy; end
        WB_SPEED_CLAMP: begin speed_x_r <= sqx; speed_y_r <= sqy; end
        WB_W:           begin wx_r <= sqx; wy_r <= sqy; end
        WB_SPEED_ADD: begin
          speed_x_r <= sat34(34'(speed_x_r) + 34'(push_x_r));
          speed_y_r <= sat34(34'(speed_y_r) + 34'(push_y_r));
        end
        WB_PLACE: begin
          place_x_r <= sat34(34'(place_x_r) + 34'(speed_x_r));
          place_y_r <= sat34(34'(place_y_r) + 34'(speed_y_r));
        end
        WB_PUSH_UPD: begin
          push_x_r <= sat34(34'(push_x_r) + 34'(wx_r) - 34'(speed_x_r));
          push_y_r <= sat34(34'(push_y_r) + 34'(wy_r) - 34'(speed_y_r));
        end
        WB_GOAL: begin
          goal_x_r  <= in_tx;
          goal_y_r  <= in_ty;
          reached_r <= 1'b0;
        end
        WB_REACH: if (near) reached_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // result register, separate from the working state
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x_r   <= place_x_r;
      pos_y_r   <= place_y_r;
      vel_x_r   <= speed_x_r;
      vel_y_r   <= speed_y_r;
      at_goal_r <= reached_r;
    end
  end

  assign pos_x   = pos_x_r;
  assign pos_y   = pos_y_r;
  assign vel_x   = vel_x_r;
  assign vel_y   = vel_y_r;
  assign at_goal = at_goal_r;
endmodule

// File: rtl/sss_ctrl.sv
// Sequencer: stores a new goal, or walks arrival check, push clamp, speed clamp and goal direction.
// Depends on sss_pkg.
module sss_ctrl import sss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic   out_valid_r, out_valid_nxt;
  state_t post;

  always_comb begin
    case (ph_r)
      PH_PUSH:  post = ST_SPADD;
      PH_SPEED: post = ST_PLACE;
      PH_DIR:   post = ST_PUPD;
      default:  post = ST_LD;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (ph_r)
      PH_ARR:  cmd.m_sel = M_RADIUS;
      PH_PUSH: cmd.m_sel = M_PUSH;
      default: cmd.m_sel = M_SPEED;
    endcase
    case (state_r)
      ST_IDLE: if (in_valid) begin
        if (in_op) begin
          cmd.wb    = WB_GOAL;
          state_nxt = ST_FIN;
        end else begin
          ph_nxt    = PH_ARR;
          state_nxt = ST_LD;
        end
      end
      ST_LD: begin
        case (ph_r)
          PH_PUSH:  cmd.ld_sel = LD_PUSH;
          PH_SPEED: cmd.ld_sel = LD_SPEED;
          default:  cmd.ld_sel = LD_DIR;
        endcase
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        cmd.mul_sel = MUL_XX;
        state_nxt   = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_sel = MUL_YY;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_MM;
      end
      ST_MM: begin
        cmd.mul_sel = MUL_MM;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (ph_r == PH_ARR) begin
          cmd.wb    = WB_REACH;
          ph_nxt    = PH_PUSH;
          state_nxt = ST_LD;
        end else if ((ph_r == PH_DIR) ? sts.nz : sts.gt) begin
          cmd.root_go = 1'b1;
          state_nxt   = ST_ROOT;
        end else begin
          state_nxt = post;
        end
      end
      ST_ROOT: if (!sts.root_busy) state_nxt = ST_MULX;
      ST_MULX: begin
        cmd.mul_sel = MUL_XM;
        state_nxt   = ST_MULY;
      end
      ST_MULY: begin
        cmd.mul_sel = MUL_YM;
        cmd.cap_x   = 1'b1;
        state_nxt   = ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: if (!sts.div_busy) state_nxt = ST_WB;
      ST_WB: begin
        case (ph_r)
          PH_PUSH:  cmd.wb = WB_PUSH_CLAMP;
          PH_SPEED: cmd.wb = WB_SPEED_CLAMP;
          default:  cmd.wb = WB_W;
        endcase
        state_nxt = post;
      end
      ST_SPADD: begin
        cmd.wb    = WB_SPEED_ADD;
        ph_nxt    = PH_SPEED;
        state_nxt = ST_LD;
      end
      ST_PLACE: begin
        cmd.wb    = WB_PLACE;
        ph_nxt    = PH_DIR;
        state_nxt = ST_LD;
      end
      ST_PUPD: begin
        cmd.wb    = WB_PUSH_UPD;
        state_nxt = ST_FIN;
      end
      ST_FIN: if (!out_valid_r || out_ready) begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_ARR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
endmodule

// File: rtl/steering_seek_step.sv
// Top level of the 2-D seek-steering point: config registers, sequencer, datapath.
// Depends on sss_pkg, sss_if, sss_ctrl, sss_dp.
//
// Use:
//   in_ch  beat: operation (0 tick, 1 set goal), target_x/target_y (Q16.16).
//   out_ch beat: position, velocity and at_goal after that item.
//   One result beat per input beat, in order, one item processed at a time.
//   cfg_we/cfg_index/cfg_data write max_speed, max_push, arrive_radius,
//   start_x, start_y; write only while idle. Start value writes are ignored
//   and reset zeroes place, so place always comes up at zero.
// Sequence:
//   set goal: the goal is stored when the beat is taken, then the result is loaded.
//   tick: arrival test and three length stages (push clamp,
//   speed clamp, goal direction), each first forming the squares, plus
//   a square root and then two dividers running side by side when a clamp
//   or scale is needed. A new beat is taken only once the sequencer is idle.
// Reset: synchronous, rst_n low; state and limits go to their reset values.
// Stall: a finished result sits in the output register while the next beat
//   can already be taken; a second result waits until out_ch.ready.
module steering_seek_step import sss_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sss_in_if.sink      in_ch,
  sss_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam logic [63:0] CFG_MAX  = 64'((1 << CFG_W) - 1);
  localparam logic [63:0] ONE_RAW  = 64'd1 << FRAC_BITS;
  localparam logic [CFG_W-1:0] SPEED_RST =
    CFG_W'((ONE_RAW > CFG_MAX) ? CFG_MAX : ONE_RAW);
  localparam logic [CFG_W-1:0] PUSH_RST =
    CFG_W'((ONE_RAW * 5 > CFG_MAX) ? CFG_MAX : ONE_RAW * 5);
  localparam logic [CFG_W-1:0] RADIUS_RST =
    CFG_W'((ONE_RAW * 10 > CFG_MAX) ? CFG_MAX : ONE_RAW * 10);

  logic [CFG_W-1:0] max_speed_r, max_push_r, arrive_radius_r;
  cmd_t cmd;
  sts_t sts;

  // start_x/start_y writes are accepted but have no later effect
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r     <= SPEED_RST;
      max_push_r      <= PUSH_RST;
      arrive_radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SPEED:     max_speed_r     <= cfg_data[CFG_W-1:0];
        CFG_MAX_PUSH:      max_push_r      <= cfg_data[CFG_W-1:0];
        CFG_ARRIVE_RADIUS: arrive_radius_r <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  sss_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts, .cmd
  );

  sss_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .max_speed    (max_speed_r),
    .max_push     (max_push_r),
    .arrive_radius(arrive_radius_r),
    .in_tx  (in_ch.target_x),
    .in_ty  (in_ch.target_y),
    .pos_x  (out_ch.position_x),
    .pos_y  (out_ch.position_y),
    .vel_x  (out_ch.velocity_x),
    .vel_y  (out_ch.velocity_y),
    .at_goal(out_ch.at_goal)
  );
endmodule

// File: rtl/sss_chk.sv
// Port-level checks for steering_seek_step, attached by bind.
// Depends on sss_if through the bound top level's channel ports.
module sss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_px
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out beat dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_px)) else $error("out payload moved");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("out valid after reset");
endmodule

bind steering_seek_step sss_chk u_sss_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_px   (out_ch.position_x)
);

// File: test/sss_tb_pkg.sv
`timescale 1ns / 100ps
// Beat types for the seek-steering testbench.
// No package dependencies.
package sss_tb_pkg;

  typedef enum logic {OP_TICK = 1'b0, OP_SET_GOAL = 1'b1} seek_op_t;

  typedef struct {
    seek_op_t           op;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } seek_cmd_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               arrived;
  } seek_state_t;

endpackage

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for steering_seek_step: directed and random beats,
// a bit-exact seek predictor, random idling on both channels.
// Depends on sss_pkg, sss_tb_pkg, sss_if and the RTL.
module testbench;
  import sss_pkg::*;
  import sss_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sss_in_if  in_ch ();
  sss_out_if out_ch ();

  steering_seek_step uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the limits and the point state
  logic [22:0] lim_speed, lim_push, lim_radius;
  logic signed [31:0] pl_x, pl_y, sp_x, sp_y, pu_x, pu_y, go_x, go_y;
  logic reached_q;

  seek_cmd_t   pending_beats[$];
  seek_state_t expected_states[$];
  int  errors = 0;
  bit  no_idle = 0;      // long stretch with both sides busy
  bit  hold_off = 0;     // receiver hold-off in progress
  bit  in_taken = 0;     // offered beat taken at the last rising edge
  event hold_req;

  function automatic logic signed [31:0] sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint signed_as(input longint s, input longint unsigned m);
    return s < 0 ? -longint'(m) : longint'(m);
  endfunction

  // shrink a vector to length lim when it is longer
  task automatic limit_len(inout logic signed [31:0] x, inout logic signed [31:0] y,
                           input logic [22:0] lim);
    longint unsigned ax, ay, sq, len, m;
    ax = mag(longint'(x));
    ay = mag(longint'(y));
    m = lim;
    sq = ax * ax + ay * ay;
    if (sq > m * m) begin
      len = floor_sqrt(sq);
      x = 32'(signed_as(longint'(x), ax * m / len));
      y = 32'(signed_as(longint'(y), ay * m / len));
    end
  endtask

  task automatic seek_tick();
    longint dx, dy, wx, wy;
    longint unsigned ax, ay, sq, len, r;
    wx = 0;
    wy = 0;
    r = lim_radius;
    dx = longint'(go_x) - longint'(pl_x);
    dy = longint'(go_y) - longint'(pl_y);
    ax = mag(dx);
    ay = mag(dy);
    if (ax < r && ay < r && ax * ax + ay * ay < r * r) reached_q = 1'b1;
    limit_len(pu_x, pu_y, lim_push);
    sp_x = sat(longint'(sp_x) + longint'(pu_x));
    sp_y = sat(longint'(sp_y) + longint'(pu_y));
    limit_len(sp_x, sp_y, lim_speed);
    pl_x = sat(longint'(pl_x) + longint'(sp_x));
    pl_y = sat(longint'(pl_y) + longint'(sp_y));
    dx = longint'(go_x) - longint'(pl_x);
    dy = longint'(go_y) - longint'(pl_y);
    ax = mag(dx);
    ay = mag(dy);
    if (ax >= 64'd2147483648 || ay >= 64'd2147483648) begin
      ax >>= 1;
      ay >>= 1;
    end
    sq = ax * ax + ay * ay;
    if (sq != 0) begin
      len = floor_sqrt(sq);
      wx = signed_as(dx, ax * longint'(lim_speed) / len);
      wy = signed_as(dy, ay * longint'(lim_speed) / len);
    end
    pu_x = sat(longint'(pu_x) + wx - longint'(sp_x));
    pu_y = sat(longint'(pu_y) + wy - longint'(sp_y));
  endtask

  function automatic seek_state_t snapshot();
    seek_state_t s;
    s.px = pl_x; s.py = pl_y; s.vx = sp_x; s.vy = sp_y; s.arrived = reached_q;
    return s;
  endfunction

  // acceptance seen at the rising edge, used by the driver at the next falling edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: next beat offered at the falling edge, held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the offered beat
    end else if (pending_beats.size() != 0 &&
                 (no_idle || $urandom_range(99) >= 6)) begin
      in_ch.valid     <= 1'b1;
      in_ch.operation <= pending_beats[0].op;
      in_ch.target_x  <= pending_beats[0].tx;
      in_ch.target_y  <= pending_beats[0].ty;
      void'(pending_beats.pop_front());
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // prediction runs on the beat actually accepted
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.operation == OP_SET_GOAL) begin
        go_x = in_ch.target_x;
        go_y = in_ch.target_y;
        reached_q = 1'b0;
      end else begin
        seek_tick();
      end
      expected_states.insert(expected_states.size(), snapshot());
    end
  end

  // receiver hold-off, counted in falling edges
  always begin
    @(hold_req);
    hold_off = 1'b1;
    repeat (3000) @(negedge clk);
    hold_off = 1'b0;
  end

  // monitor: ready pattern set at falling edge, results checked at rising edge
  always @(negedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(99) >= 6;
    end
  end

  always @(posedge clk) begin
    seek_state_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_states.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_states.pop_front();
        if (out_ch.position_x !== e.px) begin
          $error("position_x expected %0d got %0d", e.px, out_ch.position_x); errors++;
        end
        if (out_ch.position_y !== e.py) begin
          $error("position_y expected %0d got %0d", e.py, out_ch.position_y); errors++;
        end
        if (out_ch.velocity_x !== e.vx) begin
          $error("velocity_x expected %0d got %0d", e.vx, out_ch.velocity_x); errors++;
        end
        if (out_ch.velocity_y !== e.vy) begin
          $error("velocity_y expected %0d got %0d", e.vy, out_ch.velocity_y); errors++;
        end
        if (out_ch.at_goal !== e.arrived) begin
          $error("at_goal expected %0b got %0b", e.arrived, out_ch.at_goal); errors++;
        end
      end
    end
  end

  // register write at one rising edge, mirrored into the predictor
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_SPEED:     lim_speed  = val[22:0];
      CFG_MAX_PUSH:      lim_push   = val[22:0];
      CFG_ARRIVE_RADIUS: lim_radius = val[22:0];
      default: ;  // start values are ignored; reset zeroes the place
    endcase
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_ch.valid && expected_states.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'($signed($urandom_range(4000000))) - 32'sd2000000;
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'h7F_FFFF;
      2: return $urandom();  // bits from 23 up ignored
      default: return $urandom_range(4194304);
    endcase
  endfunction

  task automatic queue_beat(input seek_op_t op, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    seek_cmd_t c;
    c.op = op; c.tx = x; c.ty = y;
    pending_beats.insert(pending_beats.size(), c);
  endtask

  initial begin
    seek_cmd_t c;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    out_ch.ready = 1'b0;
    lim_speed = 23'd65536; lim_push = 23'd327680; lim_radius = 23'd655360;
    pl_x = 0; pl_y = 0; sp_x = 0; sp_y = 0; pu_x = 0; pu_y = 0;
    go_x = 0; go_y = 0; reached_q = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero direction, arrival at origin, far corners, unset field bits
    queue_beat(OP_TICK, 0, 0);
    queue_beat(OP_TICK, 0, 0);
    queue_beat(OP_SET_GOAL, 32'sh7FFF_FFFF, 32'sh8000_0000);
    repeat (4) queue_beat(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_beat(OP_SET_GOAL, 32'sh8000_0000, 32'sh7FFF_FFFF);
    repeat (3) queue_beat(OP_TICK, 0, 0);
    queue_beat(OP_SET_GOAL, 32'sd300000, -32'sd200000);
    repeat (6) queue_beat(OP_TICK, 0, 0);
    drain();

    // extremes of the limits: huge speed and push, zero radius, goals at the corners
    write_reg(CFG_MAX_SPEED, 32'h7F_FFFF);
    write_reg(CFG_MAX_PUSH, 32'hFFFF_FFFF);
    write_reg(CFG_ARRIVE_RADIUS, 32'h0);
    write_reg(CFG_START_X, 32'h8000_0000);
    write_reg(CFG_START_Y, 32'h7FFF_FFFF);
    queue_beat(OP_SET_GOAL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    repeat (6) queue_beat(OP_TICK, 0, 0);
    queue_beat(OP_SET_GOAL, 32'sh8000_0000, 32'sh8000_0000);
    repeat (6) queue_beat(OP_TICK, 0, 0);
    drain();

    // random phases, each with fresh limits; mostly ticks after a goal
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(CFG_MAX_SPEED, ph == 0 ? 32'h0 : rand_limit());
      write_reg(CFG_MAX_PUSH, rand_limit());
      write_reg(CFG_ARRIVE_RADIUS, ph == 1 ? 32'h7F_FFFF : rand_limit());
      no_idle = (ph == 5 || ph == 6);
      if (ph == 3) -> hold_req;  // input backs up behind stalled output
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(9) == 0) begin
          c.op = OP_SET_GOAL;
          c.tx = rand_coord() + pl_x;
          c.ty = rand_coord() + pl_y;
        end else begin
          c.op = OP_TICK;
          c.tx = $urandom();
          c.ty = $urandom();
        end
        pending_beats.insert(pending_beats.size(), c);
      end
      drain();
    end
    if (errors == 0) begin
      $display("** steering_seek_step: PASSED **");
    end else begin
      $display("** steering_seek_step: FAILED **");
    end
    $finish;
  end

  // generous bound: ~1700 beats at worst-case sequencing plus stalls
  initial begin
    #20ms;
    $display("** steering_seek_step: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/sss_root.sv
rtl/sss_div.sv
rtl/sss_dp.sv
rtl/sss_ctrl.sv
rtl/steering_seek_step.sv
rtl/sss_chk.sv
test/sss_tb_pkg.sv
test/testbench.sv
